[rtl/srs_pkg.sv]
// Shared widths and types for the scaler ratio set-up block.
`timescale 1ns / 1ps

package srs_pkg;

  // Field widths
  localparam int SIZE_W = 13;
  localparam int BYTE_W = 8;

  // Stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 56;

  // Status of the shared divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[rtl/srs_div.sv]
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module srs_div
  import srs_pkg::*;
#(
  parameter int NW = 21,
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output div_stat_t     stat,
  output logic [NW-1:0] quotient,
  output logic [DW-1:0] remainder
);

  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [NW-1:0] num;
  logic [DW-1:0] rem;
  logic [DW-1:0] den;

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          qbit;
  logic [DW-1:0] rem_next;

  // Trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    trial    = {rem, num[NW-1]};
    diff     = trial - {1'b0, den};
    qbit     = ~diff[DW];
    rem_next = qbit ? diff[DW-1:0] : trial[DW-1:0];
  end

  // Control: load on start, count down one bit per cycle, pulse done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift dividend out and quotient bits in
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      num <= dividend;
      den <= divisor;
      rem <= '0;
    end else if (busy) begin
      num <= {num[NW-2:0], qbit};
      rem <= rem_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = num;
  assign remainder = rem;

endmodule

[rtl/scaler_ratio_setup.sv]
// Top level: gcd reduction, clamp and zoom ratios for one image dimension.
//
//   channel   dir   fields (tdata, lowest bit up)
//   s_axis    in    source_size[12:0], dest_size[25:13]
//   m_axis    out   reduced_source, reduced_dest, zoom_out, ceil_ratio,
//                   floor_ratio, separation, size_error
//
// Each gcd step is a modulo on the shared divider, whose dividend is NW bits
// wide (NW = 13 plus the width of MAX_REDUCED_STEP, 21 by default); each later
// division launches from its own state or as the one before it finishes. Two to
// four divisions follow the k gcd steps (k <= 18); a zero size skips them all.
// s_tready is high only between items. Reset is synchronous and clears the
// sequencer and the output valid. A result held on a stalled m_axis blocks
// only the final load of the next.
`timescale 1ns / 1ps

module scaler_ratio_setup
  import srs_pkg::*;
#(
  parameter int MAX_REDUCED_STEP = 128
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // source_size[12:0], dest_size[25:13], zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // reduced_source[12:0], reduced_dest[25:13], zoom_out[26], ceil_ratio[34:27],
  // floor_ratio[42:35], separation[50:43], size_error[51], zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int MW = $clog2(MAX_REDUCED_STEP + 1);
  localparam int NW = SIZE_W + MW;
  localparam logic [SIZE_W-1:0] MAX_C = SIZE_W'(MAX_REDUCED_STEP);
  localparam logic [NW-1:0]     MAX_N = NW'(MAX_REDUCED_STEP);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_GCD      = 11'b000_0000_0010,
    S_GCD_W    = 11'b000_0000_0100,
    S_DIV_RS   = 11'b000_0000_1000,
    S_DIV_RD   = 11'b000_0001_0000,
    S_CLAMP    = 11'b000_0010_0000,
    S_CL_START = 11'b000_0100_0000,
    S_CL_W     = 11'b000_1000_0000,
    S_RATIO    = 11'b001_0000_0000,
    S_RATIO_W  = 11'b010_0000_0000,
    S_DONE     = 11'b100_0000_0000
  } state_t;

  state_t state;

  logic [SIZE_W-1:0] src;
  logic [SIZE_W-1:0] dst;
  logic [SIZE_W-1:0] a;
  logic [SIZE_W-1:0] b;
  logic [SIZE_W-1:0] g;
  logic              a_gt;
  logic [SIZE_W-1:0] rs;
  logic [SIZE_W-1:0] rd;
  logic [NW-1:0]     prod;
  logic              err;
  logic              zoom;
  logic [BYTE_W-1:0] ceil_r;
  logic [BYTE_W-1:0] floor_r;
  logic [BYTE_W-1:0] sep;

  logic              div_start;
  logic [NW-1:0]     div_n;
  logic [SIZE_W-1:0] div_d;
  div_stat_t         div_stat;
  logic [NW-1:0]     div_q;
  logic [SIZE_W-1:0] div_r;

  logic              s_acc;
  logic              out_free;

  assign s_tready = (state == S_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Select the divider operands for each launch
  always_comb begin
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;
    unique case (state)
      S_GCD: begin
        div_start = 1'b1;
        if (a == '0 || b == '0) begin
          div_n = NW'(src);
          div_d = a | b;
        end else if (a > b) begin
          div_n = NW'(a);
          div_d = b;
        end else begin
          div_n = NW'(b);
          div_d = a;
        end
      end
      S_DIV_RS: begin
        div_start = div_stat.done;
        div_n     = NW'(dst);
        div_d     = g;
      end
      S_CL_START: begin
        div_start = 1'b1;
        div_n     = prod;
        div_d     = rs;
      end
      S_RATIO: begin
        div_start = (rs >= rd);
        div_n     = NW'(rs);
        div_d     = rd;
      end
      default: ;
    endcase
  end

  srs_div #(
    .NW (NW),
    .DW (SIZE_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_n),
    .divisor   (div_d),
    .stat      (div_stat),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Sequence the gcd loop, reductions, clamp and ratio
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_acc) begin
            if (s_tdata[SIZE_W-1:0] == '0 || s_tdata[2*SIZE_W-1:SIZE_W] == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_GCD;
            end
          end
        end
        S_GCD: begin
          state <= (a == '0 || b == '0) ? S_DIV_RS : S_GCD_W;
        end
        S_GCD_W: begin
          if (div_stat.done) state <= S_GCD;
        end
        S_DIV_RS: begin
          if (div_stat.done) state <= S_DIV_RD;
        end
        S_DIV_RD: begin
          if (div_stat.done) state <= S_CLAMP;
        end
        S_CLAMP: begin
          state <= (rs > MAX_C) ? S_CL_START : S_RATIO;
        end
        S_CL_START: begin
          state <= S_CL_W;
        end
        S_CL_W: begin
          if (div_stat.done) state <= S_RATIO;
        end
        S_RATIO: begin
          state <= (rs >= rd) ? S_RATIO_W : S_DONE;
        end
        S_RATIO_W: begin
          if (div_stat.done) state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Working registers of the current item
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (s_acc) begin
          src     <= s_tdata[SIZE_W-1:0];
          dst     <= s_tdata[2*SIZE_W-1:SIZE_W];
          a       <= s_tdata[SIZE_W-1:0];
          b       <= s_tdata[2*SIZE_W-1:SIZE_W];
          err     <= (s_tdata[SIZE_W-1:0] == '0 || s_tdata[2*SIZE_W-1:SIZE_W] == '0);
          rs      <= '0;
          rd      <= '0;
          zoom    <= 1'b0;
          ceil_r  <= '0;
          floor_r <= '0;
          sep     <= '0;
        end
      end
      S_GCD: begin
        a_gt <= (a > b);
        g    <= a | b;
      end
      S_GCD_W: begin
        if (div_stat.done) begin
          if (a_gt) a <= div_r;
          else      b <= div_r;
        end
      end
      S_DIV_RS: begin
        if (div_stat.done) rs <= div_q[SIZE_W-1:0];
      end
      S_DIV_RD: begin
        if (div_stat.done) rd <= div_q[SIZE_W-1:0];
      end
      S_CLAMP: begin
        prod <= NW'(rd) * MAX_N;
      end
      S_CL_W: begin
        if (div_stat.done) begin
          rd <= div_q[SIZE_W-1:0] + 1'b1;
          rs <= MAX_C;
        end
      end
      S_RATIO_W: begin
        if (div_stat.done) begin
          zoom    <= 1'b1;
          floor_r <= div_q[BYTE_W-1:0];
          ceil_r  <= div_q[BYTE_W-1:0] + BYTE_W'(div_r != '0);
          sep     <= BYTE_W'(rd - div_r);
        end
      end
      default: ;
    endcase
  end

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_tdata <= {4'b0, err, sep, floor_r, ceil_r, zoom, rd, rs};
    end
  end

  // Divider completes only while the sequencer waits on it
  assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_GCD_W || state == S_DIV_RS || state == S_DIV_RD ||
                       state == S_CL_W || state == S_RATIO_W))
    else $error("divider done outside a wait state");

  // Gcd modulo is never launched with a zero operand
  assert property (@(posedge clk) disable iff (rst)
    state == S_GCD_W |-> (a != '0 && b != '0))
    else $error("gcd step with zero operand");

  // Clamp leaves the source step within the limit and the destination step nonzero
  assert property (@(posedge clk) disable iff (rst)
    state == S_RATIO |-> rs <= MAX_C && rd != '0)
    else $error("source step above limit or zero destination step");

  // A good result always carries a nonzero destination step
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[51]) |-> m_tdata[25:13] != '0)
    else $error("valid result with zero destination step");

endmodule
